// ===== hw/rtl/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg: shared types and constants for the nearest palette color mapper
// Holds the request kinds, field widths and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

	// request kinds
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	// default palette depth
	localparam int PALETTE_ENTRIES_DEF = 256;

	// fixed field widths
	localparam int INDEX_W = 8;
	localparam int LEVEL_W = 8;
	localparam int COLOR_W = 15;
	localparam int CHAN_W  = 5;
	localparam int SQ_W    = 2 * LEVEL_W;
	localparam int DIST_W  = 18;
	localparam int ENTRY_W = 3 * LEVEL_W;

	// commands from the controller to the datapath
	typedef struct packed {
		logic start;     // latch query color, clear running minimum
		logic wr_en;     // store one palette entry from the request
		logic rd_en;     // read one entry for the scan
		logic rd_last;   // this read is the final entry
		logic load_out;  // copy the winning index to the result register
	} npcm_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic done;      // last entry has been compared
	} npcm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/npcm_dpath.sv =====
// ----------------------------------------------------------------------------
// npcm_dpath: palette memory and distance pipeline
// Stores the palette, reads one entry per cycle during a scan, forms the
// squared rgb distance over three stages and keeps the running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_dpath #(
	parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire npcm_pkg::npcm_cmd_t         cmd,
	input  wire [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
	input  wire [npcm_pkg::INDEX_W-1:0]      entry_index,
	input  wire [npcm_pkg::LEVEL_W-1:0]      red_level,
	input  wire [npcm_pkg::LEVEL_W-1:0]      green_level,
	input  wire [npcm_pkg::LEVEL_W-1:0]      blue_level,
	input  wire [npcm_pkg::COLOR_W-1:0]      color_555,
	output npcm_pkg::npcm_status_t           status,
	output logic [npcm_pkg::INDEX_W-1:0]     best_index
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int LW    = npcm_pkg::LEVEL_W;
	localparam logic [npcm_pkg::INDEX_W:0] DEPTH = (npcm_pkg::INDEX_W+1)'(PALETTE_ENTRIES);

	logic [npcm_pkg::ENTRY_W-1:0] mem [PALETTE_ENTRIES];

	logic [LW-1:0] red_q, green_q, blue_q;
	logic          wr_in_range;

	logic [npcm_pkg::ENTRY_W-1:0] rdata_s1;
	logic [IDX_W-1:0]             idx_s1, idx_s2, idx_s3;
	logic                         v_s1, v_s2, v_s3;
	logic                         last_s1, last_s2, last_s3;
	logic [npcm_pkg::SQ_W-1:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [npcm_pkg::DIST_W-1:0]  sum_s3;

	logic [npcm_pkg::DIST_W-1:0]  best_dist_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic                         have_q;
	logic                         done_q;
	logic [npcm_pkg::INDEX_W-1:0] result_q;

	logic [LW-1:0] d_r, d_g, d_b;

	assign wr_in_range = {1'b0, entry_index} < DEPTH;

	// palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_in_range) begin
			mem[entry_index[IDX_W-1:0]] <= {blue_level, green_level, red_level};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// query color, each channel widened as value * 8 + 4
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			red_q   <= {color_555[4:0],   3'b100};
			green_q <= {color_555[9:5],   3'b100};
			blue_q  <= {color_555[14:10], 3'b100};
		end
	end

	always_comb begin
		d_r = (red_q   >= rdata_s1[LW-1:0])      ? red_q   - rdata_s1[LW-1:0]
		                                           : rdata_s1[LW-1:0] - red_q;
		d_g = (green_q >= rdata_s1[2*LW-1:LW])   ? green_q - rdata_s1[2*LW-1:LW]
		                                           : rdata_s1[2*LW-1:LW] - green_q;
		d_b = (blue_q  >= rdata_s1[3*LW-1:2*LW]) ? blue_q  - rdata_s1[3*LW-1:2*LW]
		                                           : rdata_s1[3*LW-1:2*LW] - blue_q;
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		sq_r_s2 <= npcm_pkg::SQ_W'(d_r) * npcm_pkg::SQ_W'(d_r);
		sq_g_s2 <= npcm_pkg::SQ_W'(d_g) * npcm_pkg::SQ_W'(d_g);
		sq_b_s2 <= npcm_pkg::SQ_W'(d_b) * npcm_pkg::SQ_W'(d_b);
		sum_s3  <= npcm_pkg::DIST_W'(sq_r_s2) + npcm_pkg::DIST_W'(sq_g_s2)
		         + npcm_pkg::DIST_W'(sq_b_s2);
	end

	// valid and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
			have_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= cmd.rd_en;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			last_s1 <= cmd.rd_en & cmd.rd_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			done_q  <= v_s3 & last_s3;
			if (cmd.start) begin
				have_q <= 1'b0;
			end else if (v_s3) begin
				have_q <= 1'b1;
			end
		end
	end

	// running minimum, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (v_s3 && (!have_q || sum_s3 < best_dist_q)) begin
			best_dist_q <= sum_s3;
			best_idx_q  <= idx_s3;
		end
		if (cmd.load_out) begin
			result_q <= npcm_pkg::INDEX_W'(best_idx_q);
		end
	end

	assign status.done = done_q;
	assign best_index  = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/npcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcm_ctrl: request sequencer for the palette mapper
// Takes requests, issues palette writes, walks the read address through the
// palette for a query and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_ctrl #(
	parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               func,
	output logic                              out_valid,
	input  wire                               out_ready,
	output npcm_pkg::npcm_cmd_t               cmd,
	output logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
	input  wire npcm_pkg::npcm_status_t       status
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.start    = 1'b0;
		cmd.wr_en    = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.rd_last  = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == npcm_pkg::FUNC_MAP) begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_last = (cnt_q == LAST_ADDR);
				if (cnt_q == LAST_ADDR) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is pending");

	// the scan finishes only while the controller waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (state_q == ST_WAIT))
		else $error("scan completion outside the wait state");

	// a scan reads every entry without a break
	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q != LAST_ADDR) |=>
			(state_q == ST_SCAN && cnt_q == $past(cnt_q) + 1'b1))
		else $error("scan address did not advance");

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_palette_color_mapper_core.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_core: nearest palette color search, rgb555 in
// A write request stores one palette entry and gives no result.
// A map request shows its result once it has passed the palette reads, one
// per cycle, the distance pipeline and minimum, and the controller hand-off
// through its wait and hold states into the result register.
// One write per cycle while idle; no request is taken during a map request.
// Reset clears control state only; palette contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_mapper_core #(
	parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// request channel
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          func,
	input  wire [npcm_pkg::INDEX_W-1:0]  entry_index,
	input  wire [npcm_pkg::LEVEL_W-1:0]  red_level,
	input  wire [npcm_pkg::LEVEL_W-1:0]  green_level,
	input  wire [npcm_pkg::LEVEL_W-1:0]  blue_level,
	input  wire [npcm_pkg::COLOR_W-1:0]  color_555,
	// result channel
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [npcm_pkg::INDEX_W-1:0] best_index
);

	// address width follows the palette depth
	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	npcm_pkg::npcm_cmd_t    cmd;
	npcm_pkg::npcm_status_t status;
	logic [IDX_W-1:0]       rd_addr;

	// controller: accepts a request only when idle; a query may start while
	// an earlier result still waits, and holds its own result until the
	// output register is free
	npcm_ctrl #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.status    (status)
	);

	// datapath: palette memory, squared distance pipeline, running minimum
	// and the result register
	npcm_dpath #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.entry_index (entry_index),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.color_555   (color_555),
		.status      (status),
		.best_index  (best_index)
	);

endmodule

`default_nettype wire

// ===== test/nearest_palette_color_mapper_core_test.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_core_test: self-checking bench for the mapper
// Fills the whole palette, then drives corner-case writes and queries, an
// unthrottled burst and a long random mix of writes and rgb555 queries, with
// random idling on both channels. A behavioral nearest-color search keeps its
// own palette copy and predicts every best_index in order.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_mapper_core_test;

	localparam int INDEX_W = npcm_pkg::INDEX_W;
	localparam int LEVEL_W = npcm_pkg::LEVEL_W;
	localparam int COLOR_W = npcm_pkg::COLOR_W;
	localparam int CHAN_W  = npcm_pkg::CHAN_W;
	localparam int DIST_W  = npcm_pkg::DIST_W;

	localparam int ENTRIES      = npcm_pkg::PALETTE_ENTRIES_DEF;
	localparam int MAP_LATENCY  = ENTRIES + 5;   // base of the final stray-result wait
	localparam int IDLE_LIMIT   = 6000;          // cycles with no request or result accepted
	localparam int QUERY_PCT    = 40;
	localparam int BURST_ITEMS  = 120;
	localparam int RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
	} rgb_t;

	// one pending map result, with the color kept for the mismatch report
	typedef struct {
		logic [COLOR_W-1:0] color;
		logic [INDEX_W-1:0] index;
	} map_result_t;

	// dut ports, all driven to known values from time zero
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	wire                  in_ready;
	logic                 func        = npcm_pkg::FUNC_WRITE;
	logic [INDEX_W-1:0]   entry_index = '0;
	logic [LEVEL_W-1:0]   red_level   = '0;
	logic [LEVEL_W-1:0]   green_level = '0;
	logic [LEVEL_W-1:0]   blue_level  = '0;
	logic [COLOR_W-1:0]   color_555   = '0;
	wire                  out_valid;
	logic                 out_ready   = 1'b0;
	wire  [INDEX_W-1:0]   best_index;

	// predictor state: palette copy and the in-order list of pending answers
	rgb_t        palette_copy [ENTRIES];
	map_result_t pending_maps [$];
	map_result_t oldest_map;

	// idling control, set per test
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;
	int stall_left      = 0;

	// bookkeeping
	int writes_sent     = 0;
	int queries_sent    = 0;
	int results_checked = 0;
	int error_count     = 0;
	int idle_cycles     = 0;

	nearest_palette_color_mapper_core #(
		.PALETTE_ENTRIES(ENTRIES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.entry_index(entry_index),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level),
		.color_555  (color_555),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_index (best_index)
	);

	// 12 unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// squared channel difference, widened so three of them sum without overflow
	function automatic logic [DIST_W-1:0] sq_gap(input logic [LEVEL_W-1:0] a,
			input logic [LEVEL_W-1:0] b);
		logic [DIST_W-1:0] d;
		d = (a >= b) ? DIST_W'(a - b) : DIST_W'(b - a);
		return d * d;
	endfunction

	// full palette scan; strict less-than keeps the lowest index on ties
	function automatic logic [INDEX_W-1:0] nearest_index(input logic [COLOR_W-1:0] color);
		logic [LEVEL_W-1:0] qr, qg, qb;
		logic [DIST_W-1:0]  gap_sum, best_dist;
		logic [INDEX_W-1:0] best;
		// each 5-bit channel widens as value * 8 + 4
		qr = {color[4:0],   3'b100};
		qg = {color[9:5],   3'b100};
		qb = {color[14:10], 3'b100};
		best      = '0;
		best_dist = '1;   // above the largest possible distance, so entry 0 always loads
		for (int n = 0; n < ENTRIES; n++) begin
			gap_sum = sq_gap(qr, palette_copy[n].red) + sq_gap(qg, palette_copy[n].green)
				+ sq_gap(qb, palette_copy[n].blue);
			if (gap_sum < best_dist) begin
				best      = INDEX_W'(n);
				best_dist = gap_sum;
			end
		end
		return best;
	endfunction

	function automatic logic [COLOR_W-1:0] pack_555(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {b, g, r};
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// mostly back to back or short gaps, now and then a long pause
	function automatic int send_gap();
		int roll;
		if (sender_steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// called at a falling edge; returns at a falling edge after the request
	// is taken and any idle gap has passed
	task automatic send_request(input logic kind, input logic [INDEX_W-1:0] slot,
			input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
			input logic [LEVEL_W-1:0] b, input logic [COLOR_W-1:0] color);
		int gap;
		func        <= kind;
		entry_index <= slot;
		red_level   <= r;
		green_level <= g;
		blue_level  <= b;
		color_555   <= color;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// request taken at this edge: update the palette copy or queue the answer
		if (kind == npcm_pkg::FUNC_WRITE) begin
			palette_copy[slot] = '{blue: b, green: g, red: r};
			writes_sent++;
		end else begin
			pending_maps.push_back('{color: color, index: nearest_index(color)});
			queries_sent++;
		end
		@(negedge clk);
		gap = send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// one random request; queries lean toward colors near palette entries
	task automatic random_request();
		logic [COLOR_W-1:0] color;
		rgb_t               lvl;
		rgb_t               near;
		int                 roll;
		color = COLOR_W'($urandom());
		lvl   = rgb_t'($urandom());
		near  = palette_copy[$urandom_range(0, ENTRIES - 1)];
		if ($urandom_range(0, 99) < QUERY_PCT) begin
			// half random colors, half the 5-bit truncation of a stored entry
			if ($urandom_range(0, 1))
				color = pack_555(near.red[7:3], near.green[7:3], near.blue[7:3]);
			send_request(npcm_pkg::FUNC_MAP, INDEX_W'($urandom()), lvl.red, lvl.green,
				lvl.blue, color);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				// exact widened levels so some queries land on distance zero
				lvl = '{blue: {lvl.blue[7:3], 3'b100}, green: {lvl.green[7:3], 3'b100},
					red: {lvl.red[7:3], 3'b100}};
			else if (roll < 45)
				// duplicate of another entry, makes equal-distance ties
				lvl = near;
			send_request(npcm_pkg::FUNC_WRITE, INDEX_W'($urandom()), lvl.red, lvl.green,
				lvl.blue, color);
		end
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// random backpressure: short stalls mostly, sometimes a long one
	always @(negedge clk) begin
		int roll;
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left  = stall_left - 1;
		end else if (!receiver_steady && $urandom_range(0, 99) < 20) begin
			out_ready <= 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 70)
				stall_left = $urandom_range(0, 2);
			else if (roll < 95)
				stall_left = $urandom_range(3, 19);
			else
				stall_left = $urandom_range(60, 150);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// every accepted result against the oldest pending answer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_maps.size() == 0) begin
				$display("%0t: result with none pending: expected nothing, got best_index=%0d",
					$time, best_index);
				error_count++;
			end else begin
				oldest_map = pending_maps.pop_front();
				results_checked++;
				if (best_index !== oldest_map.index) begin
					$display("%0t: best_index mismatch for color 0x%h: expected %0d, got %0d",
						$time, oldest_map.color, oldest_map.index, best_index);
					error_count++;
				end
			end
		end
	end

	// watchdog: ends the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog: no request or result accepted in %0d cycles, %0d pending",
				$time, IDLE_LIMIT, pending_maps.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every slot gets written before the first query
	task automatic test_palette_fill();
		rgb_t lvl;
		for (int n = 0; n < ENTRIES; n++) begin
			lvl = rgb_t'($urandom());
			send_request(npcm_pkg::FUNC_WRITE, INDEX_W'(n), lvl.red, lvl.green, lvl.blue,
				COLOR_W'($urandom()));
		end
	endtask

	// extremes, exact hits, lowest-index ties, ignored fields, write then query
	task automatic test_corner_cases();
		// black and white at the ends; color_555 is all ones and must be ignored
		send_request(npcm_pkg::FUNC_WRITE, 8'd0,   8'h00, 8'h00, 8'h00, '1);
		send_request(npcm_pkg::FUNC_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, '1);
		// same exact match for color zero in two slots, lower one wins
		send_request(npcm_pkg::FUNC_WRITE, 8'd9,   8'd4,  8'd4,  8'd4,  '0);
		send_request(npcm_pkg::FUNC_WRITE, 8'd3,   8'd4,  8'd4,  8'd4,  '0);
		// query with every unused field at all ones
		send_request(npcm_pkg::FUNC_MAP,   '1, '1, '1, '1, '0);
		// overwrite the lower twin, now the higher one is the only exact hit
		send_request(npcm_pkg::FUNC_WRITE, 8'd3,   8'd200, 8'd17, 8'd99, '0);
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, '0);
		// brightest query, then again once an exact entry exists
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, '1);
		send_request(npcm_pkg::FUNC_WRITE, 8'd128, 8'd252, 8'd252, 8'd252, '0);
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, '1);
		// pure channels, checks the bit positions of red, green and blue
		send_request(npcm_pkg::FUNC_WRITE, 8'd40,  8'd252, 8'd4,   8'd4,   '0);
		send_request(npcm_pkg::FUNC_WRITE, 8'd41,  8'd4,   8'd252, 8'd4,   '0);
		send_request(npcm_pkg::FUNC_WRITE, 8'd42,  8'd4,   8'd4,   8'd252, '0);
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, pack_555(5'h1F, 5'h00, 5'h00));
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, pack_555(5'h00, 5'h1F, 5'h00));
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, pack_555(5'h00, 5'h00, 5'h1F));
		// two entries at equal nonzero distance either side of the query
		send_request(npcm_pkg::FUNC_WRITE, 8'd70,  8'd80, 8'd84, 8'd84, '0);
		send_request(npcm_pkg::FUNC_WRITE, 8'd71,  8'd88, 8'd84, 8'd84, '0);
		send_request(npcm_pkg::FUNC_MAP,   '0, '0, '0, '0, pack_555(5'd10, 5'd10, 5'd10));
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		sender_steady   = 1'b1;
		receiver_steady = 1'b1;
		repeat (BURST_ITEMS)
			random_request();
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// long random mix; idling switched off now and then for a stretch
	task automatic test_random_traffic();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				sender_steady   = ($urandom_range(0, 3) == 0);
				receiver_steady = ($urandom_range(0, 3) == 0);
			end
			random_request();
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_palette_fill();
		test_corner_cases();
		test_back_to_back();
		test_random_traffic();

		// drain: still at a falling edge here
		in_valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(negedge clk);
		// let any stray result show up
		repeat (MAP_LATENCY + 20) @(negedge clk);

		$display("covered %0d palette writes and %0d color queries, %0d results checked",
			writes_sent, queries_sent, results_checked);
		$display("with random idling on both channels; %0d mismatches", error_count);
		if (error_count == 0 && pending_maps.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_dpath.sv
hw/rtl/npcm_ctrl.sv
hw/rtl/nearest_palette_color_mapper_core.sv
test/nearest_palette_color_mapper_core_test.sv
